// ===== design/fsc_pkg.sv =====
`default_nettype none

package fsc_pkg;

  // Default number of receive queues that can have a socket bound
  localparam int QUEUE_COUNT_DEF = 64;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int QUEUE_W  = 6;
  localparam int POS_W    = 7;
  localparam int ADDR_W   = 32;
  localparam int MASK_W   = 64;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_SRC  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOCK_MASK  = 1'b1;

  // Frame byte offsets, Ethernet header included
  localparam logic [POS_W-1:0] POS_IP_START = 7'd14;
  localparam logic [POS_W-1:0] POS_TLEN_HI  = 7'd16;
  localparam logic [POS_W-1:0] POS_TLEN_LO  = 7'd17;
  localparam logic [POS_W-1:0] POS_PROTO    = 7'd23;
  localparam logic [POS_W-1:0] POS_SRC_FIRST = 7'd26;
  localparam logic [POS_W-1:0] POS_SRC_LAST  = 7'd29;
  localparam logic [POS_W-1:0] POS_SAT      = 7'd127;
  localparam logic [POS_W-1:0] MIN_IP_LEN   = 7'd34;
  localparam logic [POS_W-1:0] L4_DOFF_OFS  = 7'd12;
  localparam logic [POS_W-1:0] L4_FLAG_OFS  = 7'd13;
  localparam logic [POS_W-1:0] TCP_HDR_LEN  = 7'd20;
  localparam logic [POS_W-1:0] UDP_HDR_LEN  = 7'd8;

  localparam logic [3:0] IP_VERSION_4 = 4'd4;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // TCP flag bits
  localparam int FLAG_FIN = 0;
  localparam int FLAG_SYN = 1;
  localparam int FLAG_RST = 2;
  localparam int FLAG_ACK = 4;

  typedef enum logic [1:0] {
    VERDICT_DROP     = 2'd0,
    VERDICT_PASS     = 2'd1,
    VERDICT_REDIRECT = 2'd2,
    VERDICT_ABORTED  = 2'd3
  } verdict_t;

endpackage

`default_nettype wire

// ===== design/fsc_in_if.sv =====
`default_nettype none

// Frame byte channel
interface fsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;
  logic [5:0] queue_number;

  modport source (output valid, output frame_byte, output end_of_frame,
                  output queue_number, input ready);
  modport sink   (input valid, input frame_byte, input end_of_frame,
                  input queue_number, output ready);
endinterface

`default_nettype wire

// ===== design/fsc_out_if.sv =====
`default_nettype none

// Verdict channel
interface fsc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [5:0] target_queue;

  modport source (output valid, output verdict, output target_queue, input ready);
  modport sink   (input valid, input verdict, input target_queue, output ready);
endinterface

`default_nettype wire

// ===== design/ipv4_flow_steering_classifier.sv =====
`default_nettype none

// The verdict is registered when the final byte of a frame is accepted.
// Throughput: one frame byte per cycle; the header fields are captured in place
// and the verdict logic sits between the field registers and the output register.
// The input stalls only when a verdict is held and not yet taken.
// Reset (synchronous, rst_n low): frame state cleared, source match 0, mask all ones.
module ipv4_flow_steering_classifier
  import fsc_pkg::*;
#(
  parameter int QUEUE_COUNT = QUEUE_COUNT_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_wr_en,
  input  wire [CFG_IDX_W-1:0]    cfg_index,
  input  wire [CFG_DATA_W-1:0]   cfg_data,
  fsc_in_if.sink                 in_chan,
  fsc_out_if.source              out_chan
);

  // Configuration registers
  logic [ADDR_W-1:0]      match_src_r;
  logic [QUEUE_COUNT-1:0] sock_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_src_r <= '0;
      sock_mask_r <= '1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MATCH_SRC: match_src_r <= cfg_data[ADDR_W-1:0];
        CFG_SOCK_MASK: sock_mask_r <= cfg_data[QUEUE_COUNT-1:0];
        default: ;
      endcase
    end
  end

  // Frame state
  logic [POS_W-1:0]  pos_r,  pos_nxt;
  logic [3:0]        ver_r,  ver_nxt;
  logic [3:0]        ihl_r,  ihl_nxt;
  logic [15:0]       tlen_r, tlen_nxt;
  logic [7:0]        proto_r, proto_nxt;
  logic [ADDR_W-1:0] src_r,  src_nxt;
  logic [3:0]        doff_r, doff_nxt;
  logic [7:0]        flags_r, flags_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  verdict_t         verdict_r,   verdict_nxt;
  logic [QUEUE_W-1:0] target_r,  target_nxt;

  logic in_accept;
  logic out_accept;

  assign in_chan.ready = out_chan.ready || !out_valid_r;
  assign in_accept     = in_chan.valid && in_chan.ready;
  assign out_accept    = out_valid_r && out_chan.ready;

  // Field values including the current byte
  logic [3:0]        ver_cap, ihl_cap, doff_cap;
  logic [15:0]       tlen_cap;
  logic [7:0]        proto_cap, flags_cap;
  logic [ADDR_W-1:0] src_cap;
  logic [POS_W-1:0]  l4_start, len;
  logic [7:0]        b;

  assign b = in_chan.frame_byte;

  always_comb begin
    ver_cap   = ver_r;
    ihl_cap   = ihl_r;
    tlen_cap  = tlen_r;
    proto_cap = proto_r;
    src_cap   = src_r;
    doff_cap  = doff_r;
    flags_cap = flags_r;
    if (pos_r == POS_IP_START) begin
      ver_cap = b[7:4];
      ihl_cap = b[3:0];
    end
    if (pos_r == POS_TLEN_HI) tlen_cap[15:8] = b;
    if (pos_r == POS_TLEN_LO) tlen_cap[7:0]  = b;
    if (pos_r == POS_PROTO)   proto_cap = b;
    if (pos_r >= POS_SRC_FIRST && pos_r <= POS_SRC_LAST) begin
      src_cap = {src_r[ADDR_W-9:0], b};
    end
    // transport header start follows the header length just captured
    l4_start = POS_IP_START + {1'b0, ihl_cap, 2'b00};
    if (pos_r == l4_start + L4_DOFF_OFS) doff_cap  = b[7:4];
    if (pos_r == l4_start + L4_FLAG_OFS) flags_cap = b;
    len = (pos_r == POS_SAT) ? pos_r : pos_r + 7'd1;
  end

  // Verdict
  logic [6:0]        hdr_bytes;
  logic              tcp_empty;
  logic              sock_ok;
  logic [MASK_W-1:0] mask_ext;
  verdict_t          decision;
  logic [QUEUE_W-1:0] decision_q;
  verdict_t          delivered;

  always_comb begin
    hdr_bytes = {({1'b0, ihl_cap} + {1'b0, doff_cap}), 2'b00};
    tcp_empty = (tlen_cap == {9'd0, hdr_bytes});
    mask_ext  = MASK_W'(sock_mask_r);
    sock_ok   = ({1'b0, in_chan.queue_number} < 7'(QUEUE_COUNT)) &&
                mask_ext[in_chan.queue_number];
    delivered = sock_ok ? VERDICT_REDIRECT : VERDICT_ABORTED;

    decision = VERDICT_PASS;
    if (len < MIN_IP_LEN) begin
      decision = VERDICT_DROP;
    end else if (ver_cap != IP_VERSION_4) begin
      decision = VERDICT_PASS;
    end else if (len < l4_start) begin
      decision = VERDICT_DROP;
    end else if (src_cap != match_src_r) begin
      decision = VERDICT_PASS;
    end else if (proto_cap == PROTO_TCP) begin
      if (len < l4_start + TCP_HDR_LEN) begin
        decision = VERDICT_DROP;
      end else if (flags_cap[FLAG_FIN] || flags_cap[FLAG_SYN] || flags_cap[FLAG_RST]) begin
        decision = VERDICT_PASS;
      end else if (flags_cap[FLAG_ACK] && tcp_empty) begin
        decision = VERDICT_PASS;
      end else begin
        decision = delivered;
      end
    end else if (proto_cap == PROTO_UDP) begin
      decision = (len < l4_start + UDP_HDR_LEN) ? VERDICT_DROP : delivered;
    end
    decision_q = (decision == VERDICT_REDIRECT) ? in_chan.queue_number : '0;
  end

  // Next state
  always_comb begin
    pos_nxt   = pos_r;
    ver_nxt   = ver_r;
    ihl_nxt   = ihl_r;
    tlen_nxt  = tlen_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    doff_nxt  = doff_r;
    flags_nxt = flags_r;
    out_valid_nxt = out_accept ? 1'b0 : out_valid_r;
    verdict_nxt   = verdict_r;
    target_nxt    = target_r;
    if (in_accept) begin
      if (in_chan.end_of_frame) begin
        pos_nxt   = '0;
        ver_nxt   = '0;
        ihl_nxt   = '0;
        tlen_nxt  = '0;
        proto_nxt = '0;
        src_nxt   = '0;
        doff_nxt  = '0;
        flags_nxt = '0;
        out_valid_nxt = 1'b1;
        verdict_nxt   = decision;
        target_nxt    = decision_q;
      end else begin
        pos_nxt   = len;
        ver_nxt   = ver_cap;
        ihl_nxt   = ihl_cap;
        tlen_nxt  = tlen_cap;
        proto_nxt = proto_cap;
        src_nxt   = src_cap;
        doff_nxt  = doff_cap;
        flags_nxt = flags_cap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      ver_r   <= '0;
      ihl_r   <= '0;
      tlen_r  <= '0;
      proto_r <= '0;
      src_r   <= '0;
      doff_r  <= '0;
      flags_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      ver_r   <= ver_nxt;
      ihl_r   <= ihl_nxt;
      tlen_r  <= tlen_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      doff_r  <= doff_nxt;
      flags_r <= flags_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Verdict payload, no reset needed
  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
    target_r  <= target_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.verdict      = verdict_r;
  assign out_chan.target_queue = target_r;

  // Checks

  // a final byte always leaves a verdict waiting
  a_eof_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_chan.end_of_frame |=> out_valid_r)
    else $error("final byte accepted without a verdict");

  // frame state restarts after the final byte
  a_eof_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_chan.end_of_frame |=> pos_r == '0)
    else $error("byte position not cleared after frame end");

  // a mid-frame byte always leaves the position nonzero (it saturates at 127)
  a_mid_advances: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !in_chan.end_of_frame |=> pos_r != '0)
    else $error("byte position lost within a frame");

  // target queue only carries a value for redirects
  a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && verdict_r != VERDICT_REDIRECT |-> target_r == '0)
    else $error("target queue set on a non-redirect verdict");

  // a redirect never names a queue without a socket slot
  a_redirect_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && verdict_r == VERDICT_REDIRECT |-> {1'b0, target_r} < 7'(QUEUE_COUNT))
    else $error("redirect to a queue beyond the socket table");

endmodule

`default_nettype wire
